// ===== rtl/vector3_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_defines
// Assertion macros for the checker file of the vector ALU.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never seen
`define VAU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// Widths, opcodes, types and per-stage step functions of the vector ALU.
// ----------------------------------------------------------------------------
package vau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MODE_BITS = 4;

    localparam int EW   = WORD_BITS + 1;
    localparam int PW   = 2 * WORD_BITS + 2;
    localparam int XW   = 2 * WORD_BITS + 4;
    localparam int RB   = WORD_BITS + 1;
    localparam int REMW = WORD_BITS + 3;
    localparam int QB   = FRAC_BITS + 2;
    localparam int QX   = QB - FRAC_BITS;

    // accept edge to done strobe, in clock edges
    localparam int LATENCY = RB + QB + 5;

    localparam logic [MODE_BITS-1:0] MODE_ADD       = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_DIFF      = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_CROSS     = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_DOT       = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_MAG       = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_MAGSQR    = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_DIST      = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_DISTSQR   = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_SCALE     = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_NORMALIZE = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_COS       = 4'd10;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 ovf;
    } sat_t;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [RB-1:0]   root;
        logic [PW-1:0]   src;
    } rt_t;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QB-1:0] nlow;
        logic [QB-1:0] quo;
    } dv_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]           mode;
        logic [2:0][WORD_BITS-1:0]      ev;
        logic [WORD_BITS-1:0]           es;
        logic                           eflag;
        logic                           dot_neg;
        logic [PW-1:0]                  dot_mag;
        logic [2:0]                     a_neg;
        logic [2:0][WORD_BITS-1:0]      amag;
    } side_t;

    function automatic sat_t sat_word(input logic signed [XW-1:0] v);
        logic [XW-WORD_BITS:0] top;
        sat_t                  r;
        top = v[XW-1:WORD_BITS-1];
        if ((&top) || !(|top))
        begin
            r.val = v[WORD_BITS-1:0];
            r.ovf = 1'b0;
        end
        else if (v[XW-1])
        begin
            r.val = {1'b1, {(WORD_BITS-1){1'b0}}};
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = {1'b0, {(WORD_BITS-1){1'b1}}};
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // one root bit per call
    function automatic rt_t sqrt_step(input rt_t s);
        logic [REMW-1:0] r2;
        logic [REMW-1:0] trial;
        rt_t             o;
        r2    = {s.rem[REMW-3:0], s.src[PW-1:PW-2]};
        trial = {s.root, 2'b01};
        o.src = {s.src[PW-3:0], 2'b00};
        if (r2 >= trial)
        begin
            o.rem  = r2 - trial;
            o.root = {s.root[RB-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {s.root[RB-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit per call
    function automatic dv_t div_step(input dv_t s, input logic [PW-1:0] den);
        logic [PW:0] r2;
        logic [PW:0] diff;
        dv_t         o;
        r2     = {s.rem, s.nlow[QB-1]};
        diff   = r2 - {1'b0, den};
        o.nlow = {s.nlow[QB-2:0], 1'b0};
        if (r2 >= {1'b0, den})
        begin
            o.rem = diff[PW-1:0];
            o.quo = {s.quo[QB-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[PW-1:0];
            o.quo = {s.quo[QB-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== rtl/vector3_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Pipelined 3D vector ALU on signed fixed-point words.
// done pulses after the capture, add, product and sum stages, the bit-per-stage
//   root and divide stages and the output register; words are Q16.16.
// Throughput: one request per cycle; busy stays low.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [vau_pkg::MODE_BITS-1:0]         mode,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  a_x,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  a_y,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  a_z,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  b_x,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  b_y,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  b_z,
    input  logic signed [vau_pkg::WORD_BITS-1:0]  factor,
    output logic                                  done,
    output logic signed [vau_pkg::WORD_BITS-1:0]  res_x,
    output logic signed [vau_pkg::WORD_BITS-1:0]  res_y,
    output logic signed [vau_pkg::WORD_BITS-1:0]  res_z,
    output logic signed [vau_pkg::WORD_BITS-1:0]  res_scalar,
    output logic                                  saturated,
    output logic                                  zero_divisor
);

    localparam int W    = vau_pkg::WORD_BITS;
    localparam int F    = vau_pkg::FRAC_BITS;
    localparam int MB   = vau_pkg::MODE_BITS;
    localparam int EW   = vau_pkg::EW;
    localparam int PW   = vau_pkg::PW;
    localparam int XW   = vau_pkg::XW;
    localparam int RB   = vau_pkg::RB;
    localparam int QB   = vau_pkg::QB;
    localparam int QX   = vau_pkg::QX;

    // stage 1: request capture
    logic                v1_reg;
    logic [MB-1:0]       m1_reg;
    logic signed [W-1:0] a1_reg [3];
    logic signed [W-1:0] b1_reg [3];
    logic signed [W-1:0] f1_reg;

    // stage 2: component add / subtract
    logic                 v2_reg;
    logic [MB-1:0]        m2_reg;
    logic signed [W-1:0]  a2_reg [3];
    logic signed [W-1:0]  b2_reg [3];
    logic signed [W-1:0]  f2_reg;
    logic signed [EW-1:0] op2_reg [3];
    logic signed [EW-1:0] op2_next [3];
    logic signed [EW-1:0] lin2_reg [3];
    logic signed [EW-1:0] lin2_next [3];
    logic signed [EW-1:0] sum_c [3];
    logic signed [EW-1:0] dif_c [3];

    // stage 3: products
    logic                  v3_reg;
    logic [MB-1:0]         m3_reg;
    logic signed [W-1:0]   a3_reg [3];
    logic signed [EW-1:0]  lin3_reg [3];
    logic signed [W-1:0]   mulb_c [3];
    logic signed [2*W-1:0] mp3_reg [3];
    logic signed [2*W-1:0] mp3_next [3];
    logic signed [2*W-1:0] cp3_reg [6];
    logic signed [2*W-1:0] cp3_next [6];
    logic [PW-1:0]         sqa3_reg [3];
    logic [PW-1:0]         sqa3_next [3];
    logic [2*W-1:0]        sqb3_reg [3];
    logic [2*W-1:0]        sqb3_next [3];

    // stage 4: sums, shifts, early results
    logic                 v4_reg;
    logic [MB-1:0]        m4_reg;
    logic signed [W-1:0]  a4_reg [3];
    logic signed [XW-1:0] ev4_reg [3];
    logic signed [XW-1:0] ev4_next [3];
    logic signed [XW-1:0] es4_reg;
    logic signed [XW-1:0] es4_next;
    logic signed [XW-1:0] dot4_reg;
    logic signed [XW-1:0] dot4_next;
    logic [PW-1:0]        ssqa4_reg;
    logic [PW-1:0]        ssqa4_next;
    logic [PW-1:0]        ssqb4_reg;
    logic [PW-1:0]        ssqb4_next;
    logic signed [XW-1:0] cr_c [3];
    logic signed [XW-1:0] mpw_c [3];

    // root stages
    logic                  sv_reg [1:RB];
    vau_pkg::side_t        ss_reg [1:RB];
    vau_pkg::rt_t          ra_reg [1:RB];
    vau_pkg::rt_t          rb_reg [1:RB];
    vau_pkg::rt_t          ra_in;
    vau_pkg::rt_t          rb_in;
    vau_pkg::side_t        side_in;
    vau_pkg::sat_t         esat_c [3];
    vau_pkg::sat_t         ssat_c;

    // divide stages, index 0 holds the denominator (magnitude product for cosine)
    logic                  dvv_reg [0:QB];
    vau_pkg::side_t        dside_reg [0:QB];
    logic [PW-1:0]         dden_reg [0:QB];
    logic [1:0]            dzero_reg [0:QB];
    logic [RB-1:0]         dmag_reg [0:QB];
    vau_pkg::dv_t          qx_reg [0:QB];
    vau_pkg::dv_t          qy_reg [0:QB];
    vau_pkg::dv_t          qz_reg [0:QB];
    logic [PW-1:0]         den_next;
    logic [PW-1:0]         num_c [3];
    vau_pkg::dv_t          qin_c [3];
    logic [RB-1:0]         mag1_c;
    logic [RB-1:0]         mag2_c;

    // output stage
    logic                  done_reg;
    logic [W-1:0]          res_x_reg;
    logic [W-1:0]          res_y_reg;
    logic [W-1:0]          res_z_reg;
    logic [W-1:0]          res_s_reg;
    logic                  sat_reg;
    logic                  zdiv_reg;
    logic [W-1:0]          res_x_next;
    logic [W-1:0]          res_y_next;
    logic [W-1:0]          res_z_next;
    logic [W-1:0]          res_s_next;
    logic                  sat_next;
    logic                  zdiv_next;
    logic signed [XW-1:0]  qv_c [3];
    logic                  qneg_c [3];
    vau_pkg::sat_t         qsat_c [3];
    vau_pkg::sat_t         msat_c;
    vau_pkg::side_t        fside;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 1; k <= RB; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= QB; k++)
            begin
                dvv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v1_reg     <= start & ~busy;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            sv_reg[1]  <= v4_reg;
            for (int k = 2; k <= RB; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
            dvv_reg[0] <= sv_reg[RB];
            for (int k = 1; k <= QB; k++)
            begin
                dvv_reg[k] <= dvv_reg[k-1];
            end
            done_reg   <= dvv_reg[QB];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_c[i] = EW'(a1_reg[i]) + EW'(b1_reg[i]);
            dif_c[i] = EW'(a1_reg[i]) - EW'(b1_reg[i]);
            op2_next[i] = (m1_reg == vau_pkg::MODE_DIST || m1_reg == vau_pkg::MODE_DISTSQR)
                        ? dif_c[i] : EW'(a1_reg[i]);
            lin2_next[i] = (m1_reg == vau_pkg::MODE_ADD) ? sum_c[i] : dif_c[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mulb_c[i]    = (m2_reg == vau_pkg::MODE_SCALE) ? f2_reg : b2_reg[i];
            mp3_next[i]  = a2_reg[i] * mulb_c[i];
            sqa3_next[i] = op2_reg[i] * op2_reg[i];
            sqb3_next[i] = b2_reg[i] * b2_reg[i];
        end
        cp3_next[0] = a2_reg[1] * b2_reg[2];
        cp3_next[1] = a2_reg[2] * b2_reg[1];
        cp3_next[2] = a2_reg[2] * b2_reg[0];
        cp3_next[3] = a2_reg[0] * b2_reg[2];
        cp3_next[4] = a2_reg[0] * b2_reg[1];
        cp3_next[5] = a2_reg[1] * b2_reg[0];
    end

    always_comb
    begin
        dot4_next  = XW'(mp3_reg[0]) + XW'(mp3_reg[1]) + XW'(mp3_reg[2]);
        ssqa4_next = sqa3_reg[0] + sqa3_reg[1] + sqa3_reg[2];
        ssqb4_next = PW'(sqb3_reg[0]) + PW'(sqb3_reg[1]) + PW'(sqb3_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cr_c[i]  = XW'(cp3_reg[2*i]) - XW'(cp3_reg[2*i+1]);
            mpw_c[i] = XW'(mp3_reg[i]);
            case (m3_reg)
                vau_pkg::MODE_ADD,
                vau_pkg::MODE_DIFF:  ev4_next[i] = XW'(lin3_reg[i]);
                vau_pkg::MODE_CROSS: ev4_next[i] = cr_c[i] >>> F;
                vau_pkg::MODE_SCALE: ev4_next[i] = mpw_c[i] >>> F;
                default:             ev4_next[i] = '0;
            endcase
        end
        case (m3_reg)
            vau_pkg::MODE_DOT:     es4_next = dot4_next >>> F;
            vau_pkg::MODE_MAGSQR,
            vau_pkg::MODE_DISTSQR: es4_next = $signed(XW'(ssqa4_next >> F));
            default:               es4_next = '0;
        endcase
    end

    always_comb
    begin
        ra_in.rem  = '0;
        ra_in.root = '0;
        ra_in.src  = ssqa4_reg;
        rb_in.rem  = '0;
        rb_in.root = '0;
        rb_in.src  = ssqb4_reg;
        ssat_c     = vau_pkg::sat_word(es4_reg);
        side_in.mode    = m4_reg;
        side_in.es      = ssat_c.val;
        side_in.eflag   = ssat_c.ovf;
        side_in.dot_neg = dot4_reg[XW-1];
        side_in.dot_mag = dot4_reg[XW-1] ? PW'(-dot4_reg) : PW'(dot4_reg);
        for (int i = 0; i < 3; i++)
        begin
            esat_c[i]        = vau_pkg::sat_word(ev4_reg[i]);
            side_in.ev[i]    = esat_c[i].val;
            side_in.eflag    = side_in.eflag | esat_c[i].ovf;
            side_in.a_neg[i] = a4_reg[i][W-1];
            side_in.amag[i]  = a4_reg[i][W-1] ? W'(-a4_reg[i]) : W'(a4_reg[i]);
        end
    end

    always_comb
    begin
        mag1_c = ra_reg[RB].root;
        mag2_c = rb_reg[RB].root;
        if (ss_reg[RB].mode == vau_pkg::MODE_COS)
        begin
            den_next = mag1_c * mag2_c;
            num_c[0] = ss_reg[RB].dot_mag;
        end
        else
        begin
            den_next = PW'(mag1_c);
            num_c[0] = PW'(ss_reg[RB].amag[0]);
        end
        num_c[1] = PW'(ss_reg[RB].amag[1]);
        num_c[2] = PW'(ss_reg[RB].amag[2]);
        for (int i = 0; i < 3; i++)
        begin
            qin_c[i].rem  = num_c[i] >> QX;
            qin_c[i].nlow = {num_c[i][QX-1:0], {F{1'b0}}};
            qin_c[i].quo  = '0;
        end
    end

    always_comb
    begin
        fside     = dside_reg[QB];
        qneg_c[0] = (fside.mode == vau_pkg::MODE_COS) ? fside.dot_neg : fside.a_neg[0];
        qneg_c[1] = fside.a_neg[1];
        qneg_c[2] = fside.a_neg[2];
        qv_c[0]   = $signed(XW'(qx_reg[QB].quo));
        qv_c[1]   = $signed(XW'(qy_reg[QB].quo));
        qv_c[2]   = $signed(XW'(qz_reg[QB].quo));
        for (int i = 0; i < 3; i++)
        begin
            qsat_c[i] = vau_pkg::sat_word(qneg_c[i] ? -qv_c[i] : qv_c[i]);
        end
        msat_c     = vau_pkg::sat_word($signed(XW'(dmag_reg[QB])));
        res_x_next = '0;
        res_y_next = '0;
        res_z_next = '0;
        res_s_next = '0;
        sat_next   = 1'b0;
        zdiv_next  = 1'b0;
        case (fside.mode)
            vau_pkg::MODE_ADD,
            vau_pkg::MODE_DIFF,
            vau_pkg::MODE_CROSS,
            vau_pkg::MODE_SCALE:
            begin
                res_x_next = fside.ev[0];
                res_y_next = fside.ev[1];
                res_z_next = fside.ev[2];
                sat_next   = fside.eflag;
            end
            vau_pkg::MODE_DOT,
            vau_pkg::MODE_MAGSQR,
            vau_pkg::MODE_DISTSQR:
            begin
                res_s_next = fside.es;
                sat_next   = fside.eflag;
            end
            vau_pkg::MODE_MAG,
            vau_pkg::MODE_DIST:
            begin
                res_s_next = msat_c.val;
                sat_next   = msat_c.ovf;
            end
            vau_pkg::MODE_NORMALIZE:
            begin
                if (!dzero_reg[QB][0])
                begin
                    res_x_next = qsat_c[0].val;
                    res_y_next = qsat_c[1].val;
                    res_z_next = qsat_c[2].val;
                    sat_next   = qsat_c[0].ovf | qsat_c[1].ovf | qsat_c[2].ovf;
                end
            end
            vau_pkg::MODE_COS:
            begin
                if (|dzero_reg[QB])
                begin
                    zdiv_next = 1'b1;
                end
                else
                begin
                    res_s_next = qsat_c[0].val;
                    sat_next   = qsat_c[0].ovf;
                end
            end
            default:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        m1_reg    <= mode;
        a1_reg[0] <= a_x;
        a1_reg[1] <= a_y;
        a1_reg[2] <= a_z;
        b1_reg[0] <= b_x;
        b1_reg[1] <= b_y;
        b1_reg[2] <= b_z;
        f1_reg    <= factor;

        m2_reg    <= m1_reg;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        f2_reg    <= f1_reg;
        op2_reg   <= op2_next;
        lin2_reg  <= lin2_next;

        m3_reg    <= m2_reg;
        a3_reg    <= a2_reg;
        lin3_reg  <= lin2_reg;
        mp3_reg   <= mp3_next;
        cp3_reg   <= cp3_next;
        sqa3_reg  <= sqa3_next;
        sqb3_reg  <= sqb3_next;

        m4_reg    <= m3_reg;
        a4_reg    <= a3_reg;
        ev4_reg   <= ev4_next;
        es4_reg   <= es4_next;
        dot4_reg  <= dot4_next;
        ssqa4_reg <= ssqa4_next;
        ssqb4_reg <= ssqb4_next;

        ss_reg[1] <= side_in;
        ra_reg[1] <= vau_pkg::sqrt_step(ra_in);
        rb_reg[1] <= vau_pkg::sqrt_step(rb_in);
        for (int k = 2; k <= RB; k++)
        begin
            ss_reg[k] <= ss_reg[k-1];
            ra_reg[k] <= vau_pkg::sqrt_step(ra_reg[k-1]);
            rb_reg[k] <= vau_pkg::sqrt_step(rb_reg[k-1]);
        end

        dside_reg[0] <= ss_reg[RB];
        dden_reg[0]  <= den_next;
        dzero_reg[0] <= {mag2_c == '0, mag1_c == '0};
        dmag_reg[0]  <= mag1_c;
        qx_reg[0]    <= qin_c[0];
        qy_reg[0]    <= qin_c[1];
        qz_reg[0]    <= qin_c[2];
        for (int k = 1; k <= QB; k++)
        begin
            dside_reg[k] <= dside_reg[k-1];
            dden_reg[k]  <= dden_reg[k-1];
            dzero_reg[k] <= dzero_reg[k-1];
            dmag_reg[k]  <= dmag_reg[k-1];
            qx_reg[k]    <= vau_pkg::div_step(qx_reg[k-1], dden_reg[k-1]);
            qy_reg[k]    <= vau_pkg::div_step(qy_reg[k-1], dden_reg[k-1]);
            qz_reg[k]    <= vau_pkg::div_step(qz_reg[k-1], dden_reg[k-1]);
        end

        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        res_z_reg <= res_z_next;
        res_s_reg <= res_s_next;
        sat_reg   <= sat_next;
        zdiv_reg  <= zdiv_next;
    end

    assign done         = done_reg;
    assign res_x        = res_x_reg;
    assign res_y        = res_y_reg;
    assign res_z        = res_z_reg;
    assign res_scalar   = res_s_reg;
    assign saturated    = sat_reg;
    assign zero_divisor = zdiv_reg;

endmodule

// ===== rtl/vau_chk.sv =====
// ----------------------------------------------------------------------------
// vau_chk
// Port-level checks of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_defines.svh"

module vau_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [vau_pkg::MODE_BITS-1:0]        mode,
    input logic                                 done,
    input logic signed [vau_pkg::WORD_BITS-1:0] res_x,
    input logic signed [vau_pkg::WORD_BITS-1:0] res_y,
    input logic signed [vau_pkg::WORD_BITS-1:0] res_z,
    input logic signed [vau_pkg::WORD_BITS-1:0] res_scalar,
    input logic                                 saturated,
    input logic                                 zero_divisor
);

    localparam int LAG = vau_pkg::LATENCY + 1;

    `VAU_ASSERT_IMP(a_never_busy, start, !busy, "request refused")
    `VAU_ASSERT_IMP(a_done_has_req, done, $past(start && !busy && rst_n, LAG), "result without request")
    `VAU_ASSERT_IMP(a_vec_or_scalar, done, (res_scalar == 0) || (res_x == 0 && res_y == 0 && res_z == 0), "vector and scalar both set")
    `VAU_ASSERT_IMP(a_zdiv_cos, done && zero_divisor, $past(mode, LAG) == vau_pkg::MODE_COS && res_scalar == 0 && !saturated, "zero divisor outside cosine")
    `VAU_ASSERT_IMP(a_bad_mode, done && $past(mode, LAG) > vau_pkg::MODE_COS, res_x == 0 && res_y == 0 && res_z == 0 && res_scalar == 0 && !saturated && !zero_divisor, "unused opcode gave a result")

endmodule

bind vector3_arithmetic_unit vau_chk u_vau_chk (.*);
